// ===== sv/smmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// smmsd_pkg
// Shared types, widths and codes for the set statistics block: payload
// structs, controller states, datapath operations and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smmsd_pkg;

  // Set capacity and sample format
  localparam int MAX_COUNT   = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int SAMPLE_W    = 24;
  localparam int SX_SHIFT    = SAMPLE_W - SAMPLE_BITS;

  // Accumulator widths
  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int LOG_N  = $clog2(MAX_COUNT);
  localparam int SUM_W  = SAMPLE_W + LOG_N;
  localparam int PSQ_W  = 2 * SAMPLE_W - 1;
  localparam int SQS_W  = PSQ_W + LOG_N;

  // Finishing arithmetic widths
  localparam int MAG_W  = SUM_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int REM_W  = DVS_W + 1;
  localparam int ROOT_W = SAMPLE_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STD_W  = SAMPLE_W - 1;
  localparam int STEP_W = $clog2(PROD_W);

  // Iteration counts, loaded as count minus one
  localparam logic [STEP_W-1:0] MEAN_LAST = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] NMUL_LAST = STEP_W'(CNT_W - 1);
  localparam logic [STEP_W-1:0] SMUL_LAST = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] VDIV_LAST = STEP_W'(PROD_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  // Input beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       value_present;
    logic                       last;
  } smmsd_in_t;

  // Output beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic        [STD_W-1:0]    std_dev;
    logic        [CNT_W-1:0]    sample_count;
    logic                       empty_set;
    logic                       overflow;
  } smmsd_out_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_ACC,
    ST_DRAIN,
    ST_PREP,
    ST_DIV_MEAN,
    ST_MEAN_SAVE,
    ST_MUL_NS2,
    ST_SAVE_D,
    ST_MUL_SQ,
    ST_SUB_D,
    ST_MUL_NN,
    ST_DIV_INIT,
    ST_DIV_VAR,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_FINISH
  } smmsd_state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PREP,
    OP_DIV,
    OP_MEAN_SAVE,
    OP_MUL_NS2,
    OP_SAVE_D,
    OP_MUL_SQ,
    OP_SUB_D,
    OP_MUL_NN,
    OP_DIV_INIT,
    OP_SQRT_INIT,
    OP_SQRT
  } smmsd_op_e;

  typedef struct packed {
    smmsd_op_e op;
    logic      take;
    logic      load_out;
  } smmsd_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } smmsd_status_t;

endpackage

// ===== sv/smmsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// smmsd_ctrl
// Sequencer for the set statistics block: accepts samples, then steps the
// datapath through mean division, the variance products, the variance
// division and the square root, and hands the result to the output register.
// ----------------------------------------------------------------------------
module smmsd_ctrl
  import smmsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  smmsd_status_t status_i,
  output smmsd_cmd_t    cmd_o
);

  smmsd_state_e      state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic              cnt_done;

  assign in_stall_o  = (state_q != ST_ACC);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_done    = (cnt_q == '0);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.op      = OP_IDLE;
    cmd_o.take    = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_ACC: begin
        cmd_o.take = accept;
        if (accept && in_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        if (status_i.cnt_zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV_MEAN;
          cnt_d   = MEAN_LAST;
        end
      end
      ST_DIV_MEAN: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_MEAN_SAVE;
        end
      end
      ST_MEAN_SAVE: begin
        cmd_o.op = OP_MEAN_SAVE;
        state_d  = ST_MUL_NS2;
        cnt_d    = NMUL_LAST;
      end
      ST_MUL_NS2: begin
        cmd_o.op = OP_MUL_NS2;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_SAVE_D;
        end
      end
      ST_SAVE_D: begin
        cmd_o.op = OP_SAVE_D;
        state_d  = ST_MUL_SQ;
        cnt_d    = SMUL_LAST;
      end
      ST_MUL_SQ: begin
        cmd_o.op = OP_MUL_SQ;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_SUB_D;
        end
      end
      ST_SUB_D: begin
        cmd_o.op = OP_SUB_D;
        state_d  = ST_MUL_NN;
        cnt_d    = NMUL_LAST;
      end
      ST_MUL_NN: begin
        cmd_o.op = OP_MUL_NN;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = ST_DIV_VAR;
        cnt_d    = VDIV_LAST;
      end
      ST_DIV_VAR: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = ST_SQRT;
        cnt_d    = ROOT_LAST;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  // Output valid: set on load, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/smmsd_dp.sv =====
// ----------------------------------------------------------------------------
// smmsd_dp
// Datapath of the set statistics block: one registered squaring stage in
// front of the set accumulators, then a shared bit-serial multiplier,
// restoring divider and digit-by-digit square root for the finishing math.
// ----------------------------------------------------------------------------
module smmsd_dp
  import smmsd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smmsd_cmd_t    cmd_i,
  output smmsd_status_t status_o,
  input  smmsd_in_t     in_data_i,
  output smmsd_out_t    out_data_o
);

  // Input stage
  logic signed [SAMPLE_W-1:0]   x_shl;
  logic signed [SAMPLE_W-1:0]   x_in;
  logic        [SAMPLE_W-1:0]   mag_in;
  logic        [2*SAMPLE_W-1:0] sq_full;
  logic                         p_vld_q;
  logic                         p_pres_q;
  logic signed [SAMPLE_W-1:0]   p_x_q;
  logic        [PSQ_W-1:0]      p_sq_q;

  // Set accumulators
  logic        [CNT_W-1:0]    cnt_q, cnt_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic        [SQS_W-1:0]    sqs_q, sqs_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;
  logic                       drop_q, drop_d;

  // Finishing arithmetic
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [PROD_W-1:0]        quo_q, quo_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [DVS_W-1:0]         dvs_q, dvs_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [MAG_W-1:0]         mpl_q, mpl_d;
  logic [SAMPLE_W-1:0]      mean_q, mean_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  smmsd_out_t               out_q, out_d;

  logic [MAG_W-1:0]  sum_mag;
  logic [REM_W-1:0]  div_rem2;
  logic              div_ge;
  logic [REM_W-1:0]  sq_rem2;
  logic [REM_W-1:0]  sq_trial;
  logic              sq_ge;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] prod_step;
  logic [MAG_W-1:0]  mean_mag;
  logic [MAG_W-1:0]  mean_full;

  // Sign-extend the used sample bits and square the magnitude
  always_comb begin
    x_shl   = in_data_i.sample_value << SX_SHIFT;
    x_in    = x_shl >>> SX_SHIFT;
    mag_in  = x_in[SAMPLE_W-1] ? unsigned'(-x_in) : unsigned'(x_in);
    sq_full = mag_in * mag_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      p_pres_q <= in_data_i.value_present;
      p_x_q    <= x_in;
      p_sq_q   <= sq_full[PSQ_W-1:0];
    end
  end

  // Accumulate one sample per cycle while input is taken; drop samples past capacity, clear on output load
  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    sqs_d  = sqs_q;
    min_d  = min_q;
    max_d  = max_q;
    drop_d = drop_q;
    if (cmd_i.load_out) begin
      cnt_d  = '0;
      sum_d  = '0;
      sqs_d  = '0;
      min_d  = '0;
      max_d  = '0;
      drop_d = 1'b0;
    end else if (p_vld_q && p_pres_q) begin
      if (cnt_q < CNT_W'(MAX_COUNT)) begin
        if (cnt_q == '0) begin
          min_d = p_x_q;
          max_d = p_x_q;
        end else begin
          if (p_x_q < min_q) min_d = p_x_q;
          if (p_x_q > max_q) max_d = p_x_q;
        end
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + {{(SUM_W-SAMPLE_W){p_x_q[SAMPLE_W-1]}}, p_x_q};
        sqs_d = sqs_q + SQS_W'(p_sq_q);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      sqs_q  <= sqs_d;
      min_q  <= min_d;
      max_q  <= max_d;
      drop_q <= drop_d;
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);

  // Step terms of the divider, root and multiplier
  always_comb begin
    sum_mag   = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
    div_rem2  = {rem_q[REM_W-2:0], quo_q[PROD_W-1]};
    div_ge    = (div_rem2 >= REM_W'(dvs_q));
    sq_rem2   = {rem_q[REM_W-3:0], quo_q[RAD_W-1 -: 2]};
    sq_trial  = REM_W'({root_q, 2'b01});
    sq_ge     = (sq_rem2 >= sq_trial);
    case (cmd_i.op)
      OP_MUL_NS2: mcand = PROD_W'(sqs_q);
      OP_MUL_SQ:  mcand = PROD_W'(mag_q);
      default:    mcand = PROD_W'(cnt_q);
    endcase
    prod_step = {prod_q[PROD_W-2:0], 1'b0} + (mpl_q[MAG_W-1] ? mcand : '0);
    mean_mag  = quo_q[MAG_W-1:0];
    mean_full = neg_q ? (~mean_mag + MAG_W'(1)) : mean_mag;
  end

  // Advance the operation chosen by the controller
  always_comb begin
    neg_d  = neg_q;
    mag_d  = mag_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    prod_d = prod_q;
    mpl_d  = mpl_q;
    mean_d = mean_q;
    root_d = root_q;
    case (cmd_i.op)
      OP_PREP: begin
        neg_d = sum_q[SUM_W-1];
        mag_d = sum_mag;
        quo_d = {sum_mag, (PROD_W-MAG_W)'(0)};
        rem_d = '0;
        dvs_d = DVS_W'(cnt_q);
      end
      OP_DIV: begin
        rem_d = div_ge ? (div_rem2 - REM_W'(dvs_q)) : div_rem2;
        quo_d = {quo_q[PROD_W-2:0], div_ge};
      end
      OP_MEAN_SAVE: begin
        mean_d = mean_full[SAMPLE_W-1:0];
        prod_d = '0;
        mpl_d  = {cnt_q, (MAG_W-CNT_W)'(0)};
      end
      OP_MUL_NS2, OP_MUL_SQ, OP_MUL_NN: begin
        prod_d = prod_step;
        mpl_d  = {mpl_q[MAG_W-2:0], 1'b0};
      end
      OP_SAVE_D: begin
        quo_d  = prod_q;
        prod_d = '0;
        mpl_d  = mag_q;
      end
      OP_SUB_D: begin
        quo_d  = quo_q - prod_q;
        prod_d = '0;
        mpl_d  = {cnt_q, (MAG_W-CNT_W)'(0)};
      end
      OP_DIV_INIT: begin
        dvs_d = prod_q[DVS_W-1:0];
        rem_d = '0;
      end
      OP_SQRT_INIT: begin
        rem_d  = '0;
        root_d = '0;
      end
      OP_SQRT: begin
        rem_d  = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
        root_d = {root_q[ROOT_W-2:0], sq_ge};
        quo_d  = {quo_q[PROD_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  // Build the result beat
  always_comb begin
    out_d = '0;
    if (cnt_q == '0) begin
      out_d.empty_set = 1'b1;
    end else begin
      out_d.mean_value   = signed'(mean_q);
      out_d.minimum      = min_q;
      out_d.maximum      = max_q;
      out_d.std_dev      = root_q[STD_W-1:0];
      out_d.sample_count = cnt_q;
      out_d.overflow     = drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    prod_q <= prod_d;
    mpl_q  <= mpl_d;
    mean_q <= mean_d;
    root_q <= root_d;
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/set_mean_min_max_stddev.sv =====
// ----------------------------------------------------------------------------
// set_mean_min_max_stddev
// Streaming set statistics: count, mean, minimum, maximum and population
// standard deviation of signed Q15.8 samples.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle while a set runs. The beat that
// carries last closes the set: input then stalls while the datapath works
// out the result bit-serially - a 36-step mean division, two multiplies
// of 13 and 36 steps for n*S2 - S1^2, a 13-step n*n, a 72-step variance
// division and a 24-step square root - and then registers it (an empty
// set skips these steps); the next sample is taken the cycle after the
// result is registered. The result waits in an output register,
// so a stalled output holds off only the next closing beat. Samples past
// the set capacity are dropped and flagged as overflow.
module set_mean_min_max_stddev
  import smmsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  smmsd_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output smmsd_out_t out_data_o
);

  smmsd_cmd_t    cmd;
  smmsd_status_t status;

  smmsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smmsd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
